FILE: rtl/bitmap_page_allocator_top_defines.svh
// Assertion macros shared by the page allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

   // Field widths
   localparam int MW = 3;    // mode
   localparam int PW = 16;   // page number
   localparam int CW = 17;   // page counts
   localparam int SW = 2;    // status
   localparam int REQ_W = 40;
   localparam int RSP_W = 56;
   localparam int CSR_IW = 1;

   // Mode codes
   localparam logic [MW-1:0] MODE_INIT      = 3'd0;
   localparam logic [MW-1:0] MODE_ALLOC_ONE = 3'd1;
   localparam logic [MW-1:0] MODE_FREE_ONE  = 3'd2;
   localparam logic [MW-1:0] MODE_ALLOC_RUN = 3'd3;
   localparam logic [MW-1:0] MODE_FREE_RUN  = 3'd4;

   // Result status codes
   localparam logic [SW-1:0] RS_OK       = 2'd0;
   localparam logic [SW-1:0] RS_NO_SPACE = 2'd1;
   localparam logic [SW-1:0] RS_IGNORED  = 2'd2;

   // Register indexes and reset values
   localparam logic [CSR_IW-1:0] CSR_TOTAL    = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_RESERVED = 1'b1;
   localparam logic [CW-1:0] RESET_TOTAL    = 17'd65536;
   localparam logic [CW-1:0] RESET_RESERVED = 17'd512;

   typedef enum logic [3:0] {
      S_BOOT, S_BOOT_SWEEP, S_IDLE, S_DECODE, S_INIT,
      S_A1_RD, S_A1_EV, S_AR_RD, S_AR_EV, S_AR_BIT,
      S_RMW_RD, S_RMW_WR, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD_CFG, OP_CAPTURE, OP_DECODE, OP_INIT_WR, OP_READ,
      OP_A1_EVAL, OP_AR_EVAL, OP_AR_STEP, OP_RMW_WR, OP_LOAD_RSP
   } dp_op_type;

   typedef enum logic [2:0] {
      KIND_NONE, KIND_INIT, KIND_A1, KIND_AR, KIND_RMW
   } kind_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     a1_hit;
      logic     word_found;
      logic     mixed;
      logic     bit_found;
      logic     bit_last;
      logic     scan_last;
      logic     range_last;
      logic     sweep_last;
   } dp_stat_type;

endpackage

FILE: rtl/bpa_ctrl.sv
// Sequencer of the page allocator: walks each item through its word steps.
module bpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  bpa_pkg::dp_stat_type stat,
   output bpa_pkg::dp_cmd_type  cmd
);
   import bpa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_BOOT:       state_in = S_BOOT_SWEEP;
         S_BOOT_SWEEP: if (stat.sweep_last) state_in = S_IDLE;
         S_IDLE:       if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            unique case (stat.kind)
               KIND_INIT: state_in = S_INIT;
               KIND_A1:   state_in = S_A1_RD;
               KIND_AR:   state_in = S_AR_RD;
               KIND_RMW:  state_in = S_RMW_RD;
               default:   state_in = S_DONE;
            endcase
         end
         S_INIT:  if (stat.sweep_last) state_in = S_DONE;
         S_A1_RD: state_in = S_A1_EV;
         S_A1_EV: begin
            if (stat.a1_hit || stat.scan_last) state_in = S_DONE;
            else state_in = S_A1_RD;
         end
         S_AR_RD: state_in = S_AR_EV;
         S_AR_EV: begin
            priority if (stat.word_found) state_in = S_RMW_RD;
            else if (stat.mixed)          state_in = S_AR_BIT;
            else if (stat.scan_last)      state_in = S_DONE;
            else                          state_in = S_AR_RD;
         end
         S_AR_BIT: begin
            priority if (stat.bit_found) state_in = S_RMW_RD;
            else if (stat.bit_last)      state_in = stat.scan_last ? S_DONE : S_AR_RD;
            else                         state_in = S_AR_BIT;
         end
         S_RMW_RD: state_in = S_RMW_WR;
         // Read the next word of the range until the last one is written
         S_RMW_WR: state_in = stat.range_last ? S_DONE : S_RMW_RD;
         S_DONE:   if (slot_free) state_in = S_IDLE;
         default:  state_in = S_BOOT;
      endcase
   end

   // Datapath command per state
   always_comb begin
      cmd.op = OP_NOP;
      unique case (state_ff)
         S_BOOT:       cmd.op = OP_LOAD_CFG;
         S_BOOT_SWEEP: cmd.op = OP_INIT_WR;
         S_IDLE:       if (req_tvalid) cmd.op = OP_CAPTURE;
         S_DECODE:     cmd.op = OP_DECODE;
         S_INIT:       cmd.op = OP_INIT_WR;
         S_A1_RD:      cmd.op = OP_READ;
         S_A1_EV:      cmd.op = OP_A1_EVAL;
         S_AR_RD:      cmd.op = OP_READ;
         S_AR_EV:      cmd.op = OP_AR_EVAL;
         S_AR_BIT:     cmd.op = OP_AR_STEP;
         S_RMW_RD:     cmd.op = OP_READ;
         S_RMW_WR:     cmd.op = OP_RMW_WR;
         S_DONE:       if (slot_free) cmd.op = OP_LOAD_RSP;
         default:      cmd.op = OP_NOP;
      endcase
   end

   // Output slot: filled on load, emptied on transfer
   always_comb begin
      priority if (state_ff == S_DONE && slot_free) rsp_valid_in = 1'b1;
      else if (rsp_tready)                         rsp_valid_in = 1'b0;
      else                                         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/bpa_dp.sv
// Datapath of the page allocator: bitmap memory, scan registers, counters.
module bpa_dp #(
   parameter int MAX_PAGES = 65536,
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  bpa_pkg::dp_cmd_type         cmd,
   output bpa_pkg::dp_stat_type        stat,
   input  logic [bpa_pkg::REQ_W-1:0]   req_tdata,
   input  logic [bpa_pkg::CW-1:0]      cfg_total,
   input  logic [bpa_pkg::CW-1:0]      cfg_reserved,
   output logic [bpa_pkg::RSP_W-1:0]   rsp_tdata
);
   import bpa_pkg::*;

   localparam int NWORDS = MAX_PAGES / WORD_BITS;
   localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int BW = $clog2(WORD_BITS);
   localparam int LW = ((AW + BW > CW) ? AW + BW : CW) + 2;

   // Pages lo <= p < hx that fall in the word starting at base
   function automatic logic [WORD_BITS-1:0] rmask(input logic [LW-1:0] base,
                                                  input logic [LW-1:0] lo,
                                                  input logic [LW-1:0] hx);
      logic [WORD_BITS-1:0] m;
      logic [LW-1:0]        p;
      m = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         p    = base + LW'(i);
         m[i] = (p >= lo) && (p < hx);
      end
      return m;
   endfunction

   // Position of the lowest set bit
   function automatic logic [BW-1:0] lsb_idx(input logic [WORD_BITS-1:0] f);
      logic [BW-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (f[i]) idx = BW'(i);
      end
      return idx;
   endfunction

   // Bitmap store and registered read data
   logic [WORD_BITS-1:0] mem [NWORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;

   // Item and scan registers
   logic [MW-1:0] mode_ff;
   logic [PW-1:0] pg_ff;
   logic [CW-1:0] n_ff, t_ff, r_ff, fc_ff;
   logic [AW-1:0] wa_ff;
   logic [BW-1:0] bit_ff;
   logic [LW-1:0] run_ff, rs_ff, lo_ff, hx_ff;
   logic [PW-1:0] page_ff;
   logic [SW-1:0] stat_ff;

   // Result registers
   logic [PW-1:0] rsp_page_ff;
   logic [SW-1:0] rsp_stat_ff;
   logic [CW-1:0] rsp_free_ff, rsp_used_ff;

   // Request fields
   logic [MW-1:0] req_mode;
   logic [PW-1:0] req_pg;
   logic [CW-1:0] req_n;
   assign req_mode = req_tdata[MW-1:0];
   assign req_pg   = req_tdata[MW +: PW];
   assign req_n    = req_tdata[MW+PW +: CW];

   // Effective total and reserve from the registers
   logic [LW-1:0] te_l, re_l;
   assign te_l = (LW'(cfg_total) > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : LW'(cfg_total);
   assign re_l = (LW'(cfg_reserved) > te_l) ? te_l : LW'(cfg_reserved);

   // Word geometry and masks
   logic [LW-1:0]        base, next_base, t_l, n_l;
   logic [WORD_BITS-1:0] vm, f, m_init, m_rng, a1_onehot;
   logic [BW-1:0]        a1_idx;
   logic                 is_set, all_free, none_free;
   assign base      = LW'(wa_ff) << BW;
   assign next_base = base + LW'(WORD_BITS);
   assign t_l       = LW'(t_ff);
   assign n_l       = LW'(n_ff);
   assign vm        = rmask(base, LW'(1), t_l);
   assign f         = ~rdata_ff & vm;
   assign m_init    = rmask(base, '0, LW'(r_ff));
   assign m_rng     = rmask(base, lo_ff, hx_ff);
   assign a1_idx    = lsb_idx(f);
   assign a1_onehot = WORD_BITS'(1) << a1_idx;
   assign all_free  = &f;
   assign none_free = ~|f;
   assign is_set    = (mode_ff == MODE_ALLOC_RUN);

   // Run tracking
   logic [LW-1:0] run_sum, bit_page, word_start, bit_start, found_start;
   logic          fb;
   assign run_sum     = run_ff + LW'(WORD_BITS);
   assign bit_page    = base + LW'(bit_ff);
   assign fb          = f[bit_ff];
   assign word_start  = (run_ff == '0) ? base : rs_ff;
   assign bit_start   = (run_ff == '0) ? bit_page : rs_ff;
   assign found_start = (cmd.op == OP_AR_STEP) ? bit_start : word_start;

   // Item decode
   kind_type      dec_kind;
   logic [SW-1:0] dec_stat;
   logic [LW-1:0] pg_l, dec_hx;
   assign pg_l = LW'(pg_ff);

   always_comb begin
      dec_kind = KIND_NONE;
      dec_stat = RS_IGNORED;
      dec_hx   = pg_l + LW'(1);
      unique case (mode_ff)
         MODE_INIT: begin
            dec_kind = KIND_INIT;
            dec_stat = RS_OK;
         end
         MODE_ALLOC_ONE: begin
            dec_stat = RS_NO_SPACE;
            if (fc_ff != '0) dec_kind = KIND_A1;
         end
         MODE_FREE_ONE: begin
            if (pg_ff != '0 && pg_l < t_l) begin
               dec_kind = KIND_RMW;
               dec_stat = RS_OK;
            end
         end
         MODE_ALLOC_RUN: begin
            dec_stat = RS_NO_SPACE;
            if (n_ff != '0 && n_ff <= fc_ff) dec_kind = KIND_AR;
         end
         MODE_FREE_RUN: begin
            dec_hx = pg_l + n_l;
            priority if (n_ff == '0) dec_stat = RS_NO_SPACE;
            else if (pg_ff == '0 || pg_l + n_l > t_l) dec_stat = RS_IGNORED;
            else begin
               dec_kind = KIND_RMW;
               dec_stat = RS_OK;
            end
         end
         default: begin
            dec_kind = KIND_NONE;
            dec_stat = RS_IGNORED;
         end
      endcase
   end

   // Status to the sequencer
   always_comb begin
      stat.kind       = dec_kind;
      stat.a1_hit     = |f;
      stat.word_found = all_free && (run_sum >= n_l);
      stat.mixed      = !all_free && !none_free;
      stat.bit_found  = fb && (run_ff + LW'(1) == n_l);
      stat.bit_last   = (bit_ff == BW'(WORD_BITS - 1));
      stat.scan_last  = (next_base >= t_l);
      stat.range_last = (next_base >= hx_ff);
      stat.sweep_last = (wa_ff == AW'(NWORDS - 1));
   end

   // Memory write port
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = rdata_ff;
      unique case (cmd.op)
         OP_INIT_WR: begin
            mem_we    = 1'b1;
            mem_wdata = m_init;
         end
         OP_A1_EVAL: begin
            mem_we    = stat.a1_hit;
            mem_wdata = rdata_ff | a1_onehot;
         end
         OP_RMW_WR: begin
            mem_we    = 1'b1;
            mem_wdata = is_set ? (rdata_ff | m_rng) : (rdata_ff & ~m_rng);
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wa_ff] <= mem_wdata;
      if (cmd.op == OP_READ) rdata_ff <= mem[wa_ff];
   end

   // Scan and counter registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD_CFG: begin
            t_ff  <= CW'(te_l);
            r_ff  <= CW'(re_l);
            wa_ff <= '0;
         end
         OP_CAPTURE: begin
            mode_ff <= req_mode;
            pg_ff   <= req_pg;
            n_ff    <= req_n;
            t_ff    <= CW'(te_l);
            r_ff    <= CW'(re_l);
            wa_ff   <= '0;
         end
         OP_DECODE: begin
            stat_ff <= dec_stat;
            page_ff <= '0;
            lo_ff   <= pg_l;
            hx_ff   <= dec_hx;
            wa_ff   <= (dec_kind == KIND_RMW) ? AW'(pg_l >> BW) : '0;
            run_ff  <= '0;
            rs_ff   <= '0;
            bit_ff  <= '0;
         end
         OP_INIT_WR: begin
            if (stat.sweep_last) fc_ff <= t_ff - r_ff;
            else wa_ff <= wa_ff + AW'(1);
         end
         OP_A1_EVAL: begin
            if (stat.a1_hit) begin
               fc_ff   <= fc_ff - CW'(1);
               page_ff <= PW'(base + LW'(a1_idx));
               stat_ff <= RS_OK;
            end else begin
               wa_ff <= wa_ff + AW'(1);
            end
         end
         OP_AR_EVAL, OP_AR_STEP: begin
            priority if ((cmd.op == OP_AR_EVAL && stat.word_found) ||
                         (cmd.op == OP_AR_STEP && stat.bit_found)) begin
               // Run complete: mark it used in a write sweep
               page_ff <= PW'(found_start);
               stat_ff <= RS_OK;
               lo_ff   <= found_start;
               hx_ff   <= found_start + n_l;
               wa_ff   <= AW'(found_start >> BW);
               fc_ff   <= fc_ff - n_ff;
            end else if (cmd.op == OP_AR_EVAL) begin
               if (stat.mixed) begin
                  bit_ff <= '0;
               end else begin
                  run_ff <= none_free ? '0 : run_sum;
                  if (all_free && run_ff == '0) rs_ff <= base;
                  wa_ff  <= wa_ff + AW'(1);
               end
            end else begin
               if (!fb) begin
                  run_ff <= '0;
               end else begin
                  run_ff <= run_ff + LW'(1);
                  if (run_ff == '0) rs_ff <= bit_page;
               end
               bit_ff <= bit_ff + BW'(1);
               if (stat.bit_last) wa_ff <= wa_ff + AW'(1);
            end
         end
         OP_RMW_WR: begin
            if (!is_set) fc_ff <= fc_ff + CW'($countones(rdata_ff & m_rng));
            if (!stat.range_last) wa_ff <= wa_ff + AW'(1);
         end
         OP_LOAD_RSP: begin
            rsp_page_ff <= page_ff;
            rsp_stat_ff <= stat_ff;
            rsp_free_ff <= fc_ff;
            rsp_used_ff <= (t_ff > fc_ff) ? (t_ff - fc_ff) : '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_tdata = {4'b0000, rsp_used_ff, rsp_free_ff, rsp_stat_ff, rsp_page_ff};

endmodule

FILE: rtl/bitmap_page_allocator_top.sv
// Top level of the bitmap first-fit page allocator.
//
//   port group  direction  contents
//   req_*       in         mode, page_index, run_length
//   rsp_*       out        result_page, status, free_pages, used_pages
//   csr_*       in         total_pages (0), reserved_pages (1)
//
// One item at a time. Each bitmap word is read, then evaluated or written, on
// the single-port bitmap memory: alloc-one reads and evaluates each word scanned,
// alloc-run also steps bit by bit through each partly used word, frees and run
// marking read and write each word touched, and init writes every word; each
// item is decoded first and its result loaded last.
// After reset an init pass over all MAX_PAGES/WORD_BITS words (2048 by default)
// rebuilds the map; req_tready stays low meanwhile.
// A waiting result does not block the next transfer on req.
`include "bitmap_page_allocator_top_defines.svh"

module bitmap_page_allocator_top #(
   parameter int MAX_PAGES = 65536,
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // mode[2:0], page_index[18:3], run_length[35:19], zero fill
   input  logic [bpa_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // result_page[15:0], status[17:16], free_pages[34:18], used_pages[51:35]
   output logic [bpa_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_we,
   input  logic [bpa_pkg::CSR_IW-1:0]   csr_index,
   input  logic [bpa_pkg::CW-1:0]       csr_wdata
);
   import bpa_pkg::*;

   logic [CW-1:0] total_ff, reserved_ff;
   dp_cmd_type    cmd;
   dp_stat_type   stat;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= RESET_TOTAL;
         reserved_ff <= RESET_RESERVED;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL:    total_ff    <= csr_wdata;
            CSR_RESERVED: reserved_ff <= csr_wdata;
            default:      total_ff    <= total_ff;
         endcase
      end
   end

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bpa_dp #(
      .MAX_PAGES (MAX_PAGES),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .stat         (stat),
      .req_tdata    (req_tdata),
      .cfg_total    (total_ff),
      .cfg_reserved (reserved_ff),
      .rsp_tdata    (rsp_tdata)
   );

   // Only one item in work at a time
   `BPA_ASSERT_NXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "second item taken while busy")
   // A nonzero page is only reported for a completed allocation
   `BPA_ASSERT_IMP(a_page_ok, clock, reset, rsp_tvalid && (rsp_tdata[15:0] != 16'd0), rsp_tdata[17:16] == RS_OK, "page reported with failing status")
   // A new result follows a busy cycle, never an idle one
   `BPA_ASSERT_IMP(a_rsp_after_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result without work")

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the bitmap first-fit page allocator.
`timescale 1ns / 1ps

module tb;
   import bpa_pkg::*;

   localparam int MAXP = 65536;
   localparam int WATCH_LIMIT = 300000;
   localparam logic [MW-1:0] MODE_RSVD_5 = 3'd5;
   localparam logic [MW-1:0] MODE_RSVD_7 = 3'd7;

   typedef struct packed {
      logic [PW-1:0] page;
      logic [SW-1:0] status;
      logic [CW-1:0] free_pages;
      logic [CW-1:0] used_pages;
   } alloc_rsp_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_we = 1'b0;
   logic [CSR_IW-1:0]  csr_index = '0;
   logic [CW-1:0]      csr_wdata = '0;

   // Shadow allocator state
   bit                 page_map [MAXP];
   int unsigned        free_cnt;
   int unsigned        cfg_total = 65536;
   int unsigned        cfg_reserved = 512;

   alloc_rsp_t         pending_rsp [$];
   int                 mismatches = 0;
   int                 watch_cnt = 0;
   bit                 no_idle = 0;
   int                 rsp_stall = 0;

   bitmap_page_allocator_top DUT (.*);

   always #10 clock = ~clock;

   function automatic int unsigned eff_total();
      return (cfg_total > MAXP) ? MAXP : cfg_total;
   endfunction

   function automatic void shadow_init();
      int unsigned t, r;
      t = eff_total();
      r = (cfg_reserved > t) ? t : cfg_reserved;
      for (int p = 0; p < MAXP; p++) page_map[p] = (p < r);
      free_cnt = t - r;
   endfunction

   // Expected result of one request, updating the shadow map
   function automatic alloc_rsp_t predict_alloc(logic [MW-1:0] m, logic [PW-1:0] pg,
                                               logic [CW-1:0] n);
      alloc_rsp_t r;
      int unsigned t, run, s;
      t = eff_total();
      r = '0;
      r.status = RS_OK;
      case (m)
         MODE_INIT: shadow_init();
         MODE_ALLOC_ONE: begin
            r.status = RS_NO_SPACE;
            if (free_cnt != 0) begin
               for (int unsigned p = 1; p < t; p++) begin
                  if (!page_map[p]) begin
                     page_map[p] = 1;
                     free_cnt--;
                     r.page = p[PW-1:0];
                     r.status = RS_OK;
                     break;
                  end
               end
            end
         end
         MODE_FREE_ONE: begin
            if (pg == 0 || pg >= t) r.status = RS_IGNORED;
            else if (page_map[pg]) begin
               page_map[pg] = 0;
               free_cnt++;
            end
         end
         MODE_ALLOC_RUN: begin
            r.status = RS_NO_SPACE;
            if (n != 0 && n <= free_cnt) begin
               run = 0;
               for (int unsigned p = 1; p < t; p++) begin
                  if (page_map[p]) run = 0;
                  else begin
                     run++;
                     if (run == n) begin
                        s = p + 1 - n;
                        for (int unsigned k = s; k <= p; k++) page_map[k] = 1;
                        free_cnt -= n;
                        r.page = s[PW-1:0];
                        r.status = RS_OK;
                        break;
                     end
                  end
               end
            end
         end
         MODE_FREE_RUN: begin
            if (n == 0) r.status = RS_NO_SPACE;
            else if (pg == 0 || int'(pg) + int'(n) > int'(t)) r.status = RS_IGNORED;
            else begin
               for (int unsigned p = pg; p < pg + n; p++) begin
                  if (page_map[p]) begin
                     page_map[p] = 0;
                     free_cnt++;
                  end
               end
            end
         end
         default: r.status = RS_IGNORED;
      endcase
      r.free_pages = free_cnt[CW-1:0];
      r.used_pages = (t > free_cnt) ? CW'(t - free_cnt) : '0;
      return r;
   endfunction

   // One request transfer with a random lead-in gap
   task automatic send_req(logic [MW-1:0] m, logic [PW-1:0] pg, logic [CW-1:0] n);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {4'b0, n, pg, m};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(predict_alloc(m, pg, n));
   endtask

   // Drop valid and wait until every result is back
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IW-1:0] idx, logic [CW-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_TOTAL) cfg_total = 32'(val);
      else cfg_reserved = 32'(val);
   endtask

   // Result channel: random stall per result
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result check and watchdog
   always @(posedge clock) begin
      alloc_rsp_t got, want;
      if (rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[17:16], rsp_tdata[34:18], rsp_tdata[51:35]};
         rsp_stall = no_idle ? 0 : $urandom_range(0, 3);
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) watch_cnt = 0;
      else watch_cnt++;
      if (watch_cnt >= WATCH_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Reset-time map, null page, zero length and unknown modes
   task automatic test_reset_state();
      send_req(MODE_ALLOC_ONE, 0, 0);
      send_req(MODE_FREE_ONE, 512, 0);
      send_req(MODE_FREE_ONE, 0, 0);
      send_req(MODE_FREE_ONE, 16'hFFFF, 0);
      send_req(MODE_ALLOC_RUN, 0, 0);
      send_req(MODE_FREE_RUN, 600, 0);
      send_req(MODE_FREE_RUN, 0, 1);
      send_req(MODE_FREE_RUN, 16'hFFFF, 2);
      send_req(MODE_RSVD_5, 16'h1234, 17'h1FFFF);
      send_req(MODE_RSVD_7, 0, 0);
      send_req(MODE_ALLOC_RUN, 0, 17'd65536);
      send_req(MODE_ALLOC_RUN, 0, 3);
      drain();
   endtask

   // Oversized, empty and changed-after-init configurations
   task automatic test_config_extremes();
      write_csr(CSR_TOTAL, 17'h1FFFF);
      write_csr(CSR_RESERVED, 17'h1FFFF);
      send_req(MODE_INIT, 0, 0);
      send_req(MODE_ALLOC_ONE, 0, 0);
      send_req(MODE_FREE_RUN, 1, 17'd65535);
      send_req(MODE_ALLOC_RUN, 0, 17'd65535);
      drain();
      write_csr(CSR_TOTAL, 0);
      write_csr(CSR_RESERVED, 0);
      send_req(MODE_INIT, 0, 0);
      send_req(MODE_ALLOC_ONE, 0, 0);
      send_req(MODE_FREE_ONE, 1, 0);
      drain();
      write_csr(CSR_TOTAL, 17'd100);
      send_req(MODE_ALLOC_ONE, 0, 0);
      drain();
      write_csr(CSR_TOTAL, 17'd65536);
      write_csr(CSR_RESERVED, 17'd65536);
      send_req(MODE_INIT, 0, 0);
      drain();
   endtask

   // Random phases over small maps
   task automatic test_random_traffic();
      int sent, phase_len, sel;
      int unsigned t;
      logic [MW-1:0] m;
      logic [PW-1:0] pg;
      logic [CW-1:0] n;
      sent = 0;
      while (sent < 900) begin
         no_idle = ($urandom_range(0, 4) == 0);
         sel = $urandom_range(0, 9);
         if (sel == 0) t = $urandom_range(1, 63);
         else if (sel == 1) t = $urandom_range(2049, 4096);
         else t = $urandom_range(64, 2048);
         write_csr(CSR_TOTAL, CW'(t));
         if ($urandom_range(0, 7) == 0)
            write_csr(CSR_RESERVED, CW'($urandom_range(t, t + 64)));
         else write_csr(CSR_RESERVED, CW'($urandom_range(0, t / 2)));
         send_req(MODE_INIT, 0, 0);
         phase_len = $urandom_range(60, 100);
         for (int i = 0; i < phase_len; i++) begin
            sel = $urandom_range(0, 99);
            pg = PW'($urandom_range(1, (t > 1) ? t - 1 : 1));
            n = ($urandom_range(0, 4) == 0) ? CW'($urandom_range(1, 40))
                                            : CW'($urandom_range(1, 8));
            if (sel < 35) m = MODE_ALLOC_ONE;
            else if (sel < 55) m = MODE_ALLOC_RUN;
            else if (sel < 75) m = MODE_FREE_ONE;
            else if (sel < 90) m = MODE_FREE_RUN;
            else if (sel < 92) m = MODE_INIT;
            else if (sel < 95) m = MW'($urandom_range(5, 7));
            else begin
               // noise: any field value
               m = MW'($urandom_range(0, 7));
               pg = PW'($urandom());
               n = CW'($urandom());
            end
            send_req(m, pg, n);
            sent++;
         end
         drain();
      end
   endtask

   initial begin
      shadow_init();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_config_extremes();
      test_random_traffic();
      drain();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: bitmap_page_allocator_top.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/bitmap_page_allocator_top.sv
tb/tb.sv
